@@ hw/rtl/ebcc_pkg.sv @@
// Shared types, constants and helpers of the epsilon-ball center counter.
package ebcc_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int DIM         = 4;
  localparam int COMP_BITS   = 16;

  localparam int COMP_W   = 16;
  localparam int VEC_W    = DIM * COMP_W;
  localparam int SLOT_W   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int FILL_W   = $clog2(MAX_CENTERS + 1);
  localparam int SLOTS_W  = 5;
  localparam int CAP_W    = (FILL_W > SLOTS_W) ? FILL_W : SLOTS_W;
  localparam int RADIUS_W = 34;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 8;
  localparam int DIFF_W   = COMP_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int SUM_W    = PROD_W + 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(65536);
  localparam logic [SLOTS_W-1:0]  SLOTS_RST  = SLOTS_W'(16);

  typedef enum logic [1:0] {
    ACT_DROP  = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_MATCH = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 8'd0,
    CFG_SLOTS  = 8'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FILL,
    ST_DROP
  } state_e;

  typedef struct packed {
    logic signed [15:0] comp_a;
    logic signed [15:0] comp_b;
    logic signed [15:0] comp_c;
    logic signed [15:0] comp_d;
  } in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [31:0] slot_hits;
    logic [31:0] drops_total;
  } out_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } dist_res_t;

  // low COMP_BITS of the field, sign-extended to the storage width
  function automatic logic signed [COMP_W-1:0] take_comp(logic [15:0] raw);
    logic signed [COMP_BITS-1:0] t;
    t = $signed(raw[COMP_BITS-1:0]);
    return COMP_W'(t);
  endfunction

  function automatic logic [VEC_W-1:0] pack_vec(in_t din);
    logic [15:0]      raw [4];
    logic [VEC_W-1:0] v;
    raw[0] = din.comp_a;
    raw[1] = din.comp_b;
    raw[2] = din.comp_c;
    raw[3] = din.comp_d;
    v = '0;
    for (int k = 0; k < DIM; k++) begin
      v[k*COMP_W +: COMP_W] = take_comp(raw[k]);
    end
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

@@ hw/rtl/ebcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ebcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ebcc_dist.sv @@
// Squared-distance datapath: lane squares, then sum and radius compare.
module ebcc_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            flush_i,
  input  logic                            vld_i,
  input  logic [ebcc_pkg::SLOT_W-1:0]     idx_i,
  input  logic [ebcc_pkg::VEC_W-1:0]      vec_i,
  input  logic [ebcc_pkg::VEC_W-1:0]      center_i,
  input  logic [ebcc_pkg::RADIUS_W-1:0]   radius_i,
  output ebcc_pkg::dist_res_t             res_o
);

  logic [ebcc_pkg::PROD_W-1:0] prod_d [ebcc_pkg::DIM];
  logic [ebcc_pkg::PROD_W-1:0] prod_q [ebcc_pkg::DIM];
  logic                        vld1_q;
  logic [ebcc_pkg::SLOT_W-1:0] idx1_q;
  logic [ebcc_pkg::SUM_W-1:0]  sum;

  always_comb begin
    logic signed [ebcc_pkg::DIFF_W-1:0]   a;
    logic signed [ebcc_pkg::DIFF_W-1:0]   b;
    logic signed [ebcc_pkg::DIFF_W-1:0]   d;
    logic signed [ebcc_pkg::PROD_W-1:0]   sq;
    for (int k = 0; k < ebcc_pkg::DIM; k++) begin
      a  = ebcc_pkg::DIFF_W'($signed(vec_i[k*ebcc_pkg::COMP_W +: ebcc_pkg::COMP_W]));
      b  = ebcc_pkg::DIFF_W'($signed(center_i[k*ebcc_pkg::COMP_W +: ebcc_pkg::COMP_W]));
      d  = a - b;
      sq = ebcc_pkg::PROD_W'(d) * ebcc_pkg::PROD_W'(d);
      prod_d[k] = $unsigned(sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld_i && !flush_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    for (int k = 0; k < ebcc_pkg::DIM; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < ebcc_pkg::DIM; k++) begin
      sum = sum + ebcc_pkg::SUM_W'(prod_q[k]);
    end
    res_o.vld = vld1_q && !flush_i;
    res_o.hit = (sum <= ebcc_pkg::SUM_W'(radius_i));
    res_o.idx = idx1_q;
  end

endmodule

@@ hw/rtl/epsilon_ball_center_counter.sv @@
// Top level of the epsilon-ball center counter (leader clustering, squared radius).
// Usage:
//   Input channel in_valid_i/in_ready_o carries one vector per transaction.
//   Output channel out_valid_o/out_ready_i returns one result per vector:
//   action, slot, the slot's hit count after update and the drop total.
//   Config channel cfg_valid_i/cfg_ready_o writes radius_squared (index 0)
//   or slots_in_use (index 1); other indexes are ignored. Write only while idle.
// Timing:
//   Centers and hit counts live in two RAMs with registered reads.
//   A vector scans the N filled slots one per cycle, until a hit, through a
//   two-stage distance pipeline, then does a count write, a fill or a drop.
//   With no hit every filled slot is scanned; a hit ends the scan at its slot.
//   The result is registered as the engine returns to idle, where the next
//   vector is taken.
//   One vector is in work at a time; in_ready_o is high only while idle.
// Reset: clears state, fill count and drop counter and sets config to defaults;
//   RAM contents are left as is and only filled slots are ever read.
// Stall: a finished result waits in the output register while a new vector
//   is taken; the engine holds before its write-back until the register frees.
module epsilon_ball_center_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ebcc_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ebcc_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ebcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ebcc_pkg::RADIUS_W-1:0]    cfg_data_i
);

  ebcc_pkg::state_e               state_q, state_d;
  logic [ebcc_pkg::VEC_W-1:0]     vec_q, vec_d;
  logic [ebcc_pkg::FILL_W-1:0]    rd_idx_q, rd_idx_d;
  logic                           rd_vld_q, rd_vld_d;
  logic [ebcc_pkg::SLOT_W-1:0]    rd_slot_q, rd_slot_d;
  logic [ebcc_pkg::SLOT_W-1:0]    hit_slot_q, hit_slot_d;
  logic [ebcc_pkg::FILL_W-1:0]    filled_q, filled_d;
  logic [ebcc_pkg::COUNT_W-1:0]   drop_q, drop_d;
  logic [ebcc_pkg::RADIUS_W-1:0]  radius_q;
  logic [ebcc_pkg::SLOTS_W-1:0]   slots_q;
  logic                           out_valid_q, out_valid_d;
  ebcc_pkg::out_t                 out_q, out_d;
  logic                           out_free;
  logic [ebcc_pkg::CAP_W-1:0]     cap;

  logic                           c_re, c_we;
  logic [ebcc_pkg::VEC_W-1:0]     c_rdata;
  logic                           n_re, n_we;
  logic [ebcc_pkg::SLOT_W-1:0]    n_waddr;
  logic [ebcc_pkg::COUNT_W-1:0]   n_wdata, n_rdata;
  ebcc_pkg::dist_res_t            dres;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cap = (ebcc_pkg::CAP_W'(slots_q) < ebcc_pkg::CAP_W'(ebcc_pkg::MAX_CENTERS)) ?
               ebcc_pkg::CAP_W'(slots_q) : ebcc_pkg::CAP_W'(ebcc_pkg::MAX_CENTERS);

  ebcc_ram #(
    .WIDTH (ebcc_pkg::VEC_W),
    .DEPTH (ebcc_pkg::MAX_CENTERS)
  ) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (filled_q[ebcc_pkg::SLOT_W-1:0]),
    .wdata_i (vec_q),
    .re_i    (c_re),
    .raddr_i (rd_idx_q[ebcc_pkg::SLOT_W-1:0]),
    .rdata_o (c_rdata)
  );

  ebcc_ram #(
    .WIDTH (ebcc_pkg::COUNT_W),
    .DEPTH (ebcc_pkg::MAX_CENTERS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (dres.idx),
    .rdata_o (n_rdata)
  );

  ebcc_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flush_i  (state_q != ebcc_pkg::ST_SCAN),
    .vld_i    (rd_vld_q),
    .idx_i    (rd_slot_q),
    .vec_i    (vec_q),
    .center_i (c_rdata),
    .radius_i (radius_q),
    .res_o    (dres)
  );

  always_comb begin
    state_d     = state_q;
    vec_d       = vec_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    rd_slot_d   = rd_slot_q;
    hit_slot_d  = hit_slot_q;
    filled_d    = filled_q;
    drop_d      = drop_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    c_re        = 1'b0;
    c_we        = 1'b0;
    n_re        = 1'b0;
    n_we        = 1'b0;
    n_waddr     = filled_q[ebcc_pkg::SLOT_W-1:0];
    n_wdata     = ebcc_pkg::COUNT_W'(1);
    case (state_q)
      ebcc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          vec_d    = ebcc_pkg::pack_vec(in_data_i);
          rd_idx_d = '0;
          state_d  = ebcc_pkg::ST_SCAN;
        end
      end
      ebcc_pkg::ST_SCAN: begin
        if (dres.vld && dres.hit) begin
          n_re       = 1'b1;
          hit_slot_d = dres.idx;
          state_d    = ebcc_pkg::ST_UPDATE;
        end else if (rd_idx_q < filled_q) begin
          c_re      = 1'b1;
          rd_vld_d  = 1'b1;
          rd_slot_d = rd_idx_q[ebcc_pkg::SLOT_W-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else if (!rd_vld_q && !dres.vld) begin
          state_d = (ebcc_pkg::CAP_W'(filled_q) < cap) ? ebcc_pkg::ST_FILL
                                                       : ebcc_pkg::ST_DROP;
        end
      end
      ebcc_pkg::ST_UPDATE: begin
        if (out_free) begin
          n_we              = 1'b1;
          n_waddr           = hit_slot_q;
          n_wdata           = ebcc_pkg::sat_inc(n_rdata);
          out_d.action      = ebcc_pkg::ACT_MATCH;
          out_d.slot        = 4'(hit_slot_q);
          out_d.slot_hits   = n_wdata;
          out_d.drops_total = drop_q;
          out_valid_d       = 1'b1;
          state_d           = ebcc_pkg::ST_IDLE;
        end
      end
      ebcc_pkg::ST_FILL: begin
        if (out_free) begin
          c_we              = 1'b1;
          n_we              = 1'b1;
          filled_d          = filled_q + 1'b1;
          out_d.action      = ebcc_pkg::ACT_FILL;
          out_d.slot        = 4'(filled_q[ebcc_pkg::SLOT_W-1:0]);
          out_d.slot_hits   = ebcc_pkg::COUNT_W'(1);
          out_d.drops_total = drop_q;
          out_valid_d       = 1'b1;
          state_d           = ebcc_pkg::ST_IDLE;
        end
      end
      ebcc_pkg::ST_DROP: begin
        if (out_free) begin
          drop_d            = ebcc_pkg::sat_inc(drop_q);
          out_d.action      = ebcc_pkg::ACT_DROP;
          out_d.slot        = '0;
          out_d.slot_hits   = '0;
          out_d.drops_total = drop_d;
          out_valid_d       = 1'b1;
          state_d           = ebcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ebcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ebcc_pkg::ST_IDLE;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      filled_q    <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      radius_q    <= ebcc_pkg::RADIUS_RST;
      slots_q     <= ebcc_pkg::SLOTS_RST;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      filled_q    <= filled_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ebcc_pkg::CFG_RADIUS: radius_q <= cfg_data_i;
          ebcc_pkg::CFG_SLOTS:  slots_q  <= cfg_data_i[ebcc_pkg::SLOTS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q      <= vec_d;
    rd_slot_q  <= rd_slot_d;
    hit_slot_q <= hit_slot_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= ebcc_pkg::FILL_W'(ebcc_pkg::MAX_CENTERS))
    else $error("fill count beyond capacity");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ebcc_pkg::ST_FILL && out_free) |=>
      filled_q == ebcc_pkg::FILL_W'($past(filled_q) + 1'b1))
    else $error("fill did not advance fill count");

  a_match_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == ebcc_pkg::ACT_MATCH) |->
      out_data_o.slot_hits != '0)
    else $error("match reported with zero hits");

  a_drop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ebcc_pkg::ST_DROP && out_free && drop_q != '1) |=>
      drop_q == ebcc_pkg::COUNT_W'($past(drop_q) + 1'b1))
    else $error("drop counter did not advance");
`endif

endmodule

@@ verif/ebcc_checker.sv @@
// Checker for the epsilon-ball center counter: tracks centers, predicts results, compares.
module ebcc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  ebcc_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  ebcc_pkg::out_t                 out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ebcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ebcc_pkg::RADIUS_W-1:0]  cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);

  logic [ebcc_pkg::RADIUS_W-1:0]      radius_sq;
  logic [ebcc_pkg::SLOTS_W-1:0]       slots_allowed;
  logic signed [ebcc_pkg::COMP_W-1:0] centers [ebcc_pkg::MAX_CENTERS][ebcc_pkg::DIM];
  logic [ebcc_pkg::COUNT_W-1:0]       hits [ebcc_pkg::MAX_CENTERS];
  int                                 filled;
  logic [ebcc_pkg::COUNT_W-1:0]       drops;
  ebcc_pkg::out_t                     outcomes_due [$];
  ebcc_pkg::out_t                     want;
  int                                 mismatches;
  int                                 due_count;

  assign errors_o  = mismatches;
  assign pending_o = due_count;

  // COMP_BITS equals the field width, so components are taken as they are
  function automatic ebcc_pkg::out_t cluster_outcome(ebcc_pkg::in_t v);
    logic signed [ebcc_pkg::COMP_W-1:0] vec [ebcc_pkg::DIM];
    longint                             dsq;
    longint                             diff;
    int                                 cap;
    ebcc_pkg::out_t                     r;
    vec[0] = v.comp_a;
    vec[1] = v.comp_b;
    vec[2] = v.comp_c;
    vec[3] = v.comp_d;
    r = '0;
    for (int s = 0; s < filled; s++) begin
      dsq = 0;
      for (int k = 0; k < ebcc_pkg::DIM; k++) begin
        diff = longint'(vec[k]) - longint'(centers[s][k]);
        dsq += diff * diff;
      end
      if (dsq <= longint'(radius_sq)) begin
        if (hits[s] != '1) hits[s] = hits[s] + 1'b1;
        r.action      = ebcc_pkg::ACT_MATCH;
        r.slot        = 4'(s);
        r.slot_hits   = hits[s];
        r.drops_total = drops;
        return r;
      end
    end
    cap = (slots_allowed < ebcc_pkg::MAX_CENTERS) ? int'(slots_allowed)
                                                  : ebcc_pkg::MAX_CENTERS;
    if (filled < cap) begin
      for (int k = 0; k < ebcc_pkg::DIM; k++) centers[filled][k] = vec[k];
      hits[filled]  = 32'd1;
      r.action      = ebcc_pkg::ACT_FILL;
      r.slot        = 4'(filled);
      r.slot_hits   = 32'd1;
      r.drops_total = drops;
      filled++;
      return r;
    end
    if (drops != '1) drops = drops + 1'b1;
    r.action      = ebcc_pkg::ACT_DROP;
    r.drops_total = drops;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_sq     = ebcc_pkg::RADIUS_RST;
      slots_allowed = ebcc_pkg::SLOTS_RST;
      filled        = 0;
      drops         = '0;
      mismatches    = 0;
      outcomes_due.delete();
      due_count     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ebcc_pkg::CFG_RADIUS: radius_sq = cfg_data_i;
          ebcc_pkg::CFG_SLOTS:  slots_allowed = cfg_data_i[ebcc_pkg::SLOTS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none got %0h", $time, out_data_i);
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("action", 32'(want.action), 32'(out_data_i.action));
          check_field("slot", 32'(want.slot), 32'(out_data_i.slot));
          check_field("slot_hits", want.slot_hits, out_data_i.slot_hits);
          check_field("drops_total", want.drops_total, out_data_i.drops_total);
        end
      end
      if (in_valid_i && in_ready_i) outcomes_due.push_back(cluster_outcome(in_data_i));
      due_count = outcomes_due.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the epsilon-ball center counter: stimulus, pacing and verdict.
module tb;

  localparam logic [ebcc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;
  localparam logic [ebcc_pkg::RADIUS_W-1:0]  RADIUS_MAX = '1;
  localparam int                             PHASES     = 6;
  localparam int                             PHASE_LEN  = 285;

  logic                           clk_i = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  ebcc_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ebcc_pkg::out_t                 out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ebcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ebcc_pkg::RADIUS_W-1:0]  cfg_data = '0;
  int                             errors;
  int                             pending;
  logic                           pace_off = 1'b0;
  logic                           out_took = 1'b0;
  int                             ready_hold = 0;
  ebcc_pkg::in_t                  recent_vecs [$];

  always #2 clk_i = ~clk_i;

  epsilon_ball_center_counter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ebcc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // result side: after each transaction, while pacing is on, ready may be held low at random
  always @(posedge clk_i) out_took <= out_valid & out_ready;

  always @(negedge clk_i) begin : pace_results
    int h;
    h = out_took ? (pace_off ? 0 : int'($urandom_range(0, 3))) : ready_hold;
    if (h > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= h - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end
  end

  function automatic ebcc_pkg::in_t vec4(logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c, logic [15:0] d);
    ebcc_pkg::in_t v;
    v.comp_a = a;
    v.comp_b = b;
    v.comp_c = c;
    v.comp_d = d;
    return v;
  endfunction

  function automatic logic [15:0] jitter(logic [15:0] c, int amp);
    return c + 16'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // mostly near-copies of recent vectors, so hits cluster around stored centers
  function automatic ebcc_pkg::in_t make_vec();
    ebcc_pkg::in_t v;
    int            amp;
    if (recent_vecs.size() == 0 || $urandom_range(0, 9) < 3) begin
      v = ebcc_pkg::in_t'({$urandom(), $urandom()});
    end else begin
      v = recent_vecs[$urandom_range(0, recent_vecs.size() - 1)];
      amp = (1 << (4 * $urandom_range(0, 3))) - 1;
      v = vec4(jitter(v.comp_a, amp), jitter(v.comp_b, amp),
               jitter(v.comp_c, amp), jitter(v.comp_d, amp));
    end
    recent_vecs.push_back(v);
    if (recent_vecs.size() > 32) void'(recent_vecs.pop_front());
    return v;
  endfunction

  task automatic send_vec(ebcc_pkg::in_t v);
    int gap;
    gap = pace_off ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(logic [ebcc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ebcc_pkg::RADIUS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [ebcc_pkg::RADIUS_W-1:0] phase_radius [PHASES];
    logic [ebcc_pkg::RADIUS_W-1:0] phase_slots [PHASES];
    phase_radius = '{34'd1 << 20, 34'd1 << 24,
                     ebcc_pkg::RADIUS_W'({$urandom(), $urandom()}),
                     34'd0, 34'd65536, RADIUS_MAX};
    phase_slots  = '{34'd8, 34'd3, 34'd31, 34'd16, 34'd16, 34'd12};
    repeat (3) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // zero capacity: nothing stored, everything dropped
    write_reg(ebcc_pkg::CFG_SLOTS, 34'd0);
    write_reg(ebcc_pkg::CFG_RADIUS, RADIUS_MAX);
    write_reg(CFG_UNUSED, '1);
    send_vec(vec4(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vec(vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    drain();

    // two slots, exact match only
    write_reg(ebcc_pkg::CFG_SLOTS, 34'd2);
    write_reg(ebcc_pkg::CFG_RADIUS, 34'd0);
    send_vec(vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vec(vec4(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vec(vec4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vec(vec4(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vec(vec4(16'h0001, 16'h0000, 16'h0000, 16'h0000));
    send_vec(vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_vec(vec4(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    drain();

    // widest radius: even opposite corners match slot 0
    write_reg(ebcc_pkg::CFG_RADIUS, RADIUS_MAX);
    send_vec(vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_vec(vec4(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    drain();

    // unit radius: boundary distance equal to the radius matches
    write_reg(ebcc_pkg::CFG_SLOTS, 34'd4);
    write_reg(ebcc_pkg::CFG_RADIUS, 34'd65536);
    send_vec(vec4(16'h0100, 16'h0000, 16'h0000, 16'h0000));
    send_vec(vec4(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_vec(vec4(16'h0000, 16'h0000, 16'h0000, 16'h0001));
    send_vec(vec4(16'h0100, 16'h0000, 16'h0000, 16'h0101));
    drain();

    // capacity lowered below the fill count
    write_reg(ebcc_pkg::CFG_SLOTS, 34'd1);
    send_vec(vec4(16'h0100, 16'h0000, 16'h0000, 16'h0000));
    send_vec(vec4(16'h1234, 16'hedcb, 16'h5a5a, 16'ha5a5));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(ebcc_pkg::CFG_RADIUS, phase_radius[p]);
      write_reg(ebcc_pkg::CFG_SLOTS, phase_slots[p]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 40 == 0) pace_off <= (p == 4) || ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) drain();
        send_vec(make_vec());
      end
      drain();
    end

    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
